// ===== sv/hmp_pkg.sv =====
// shared types and constants of the track event parser
`timescale 1ns / 1ps
package hmp_pkg;

  localparam int VL_W = 28;

  localparam logic [7:0] STATUS_META = 8'hFF;
  localparam logic [3:0] NIB_CTRL    = 4'hB;
  localparam logic [3:0] NIB_SYS     = 4'hF;
  localparam logic [7:0] CTRL_LOOP   = 8'd110;
  localparam logic [7:0] CTRL_BRANCH = 8'd108;

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_PARAM1,
    PH_PARAM2,
    PH_MTYPE,
    PH_MLEN,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    MARK_NONE   = 2'd0,
    MARK_LOOP   = 2'd1,
    MARK_BRANCH = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_UNKNOWN  = 2'd1,
    ERR_OVERLONG = 2'd2
  } err_t;

  typedef struct packed {
    logic [15:0]     start_offset;
    logic [VL_W-1:0] delta_ticks;
    logic [31:0]     event_tick;
    logic [7:0]      status_byte;
    logic [7:0]      first_param;
    logic [7:0]      second_param;
    logic [VL_W-1:0] meta_length;
    logic [1:0]      branch_mark;
    logic [6:0]      branch_index;
    logic [31:0]     song_loop_start;
    logic [1:0]      error_code;
  } result_t;

endpackage

// ===== sv/hmp_stream_if.sv =====
// valid/ready channel interfaces for the byte input and the event result
`timescale 1ns / 1ps
interface hmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_chunk;
  logic       new_song;

  modport source (output valid, output data_byte, output new_chunk, output new_song,
                  input ready);
  modport sink   (input valid, input data_byte, input new_chunk, input new_song,
                  output ready);
endinterface

interface hmp_event_if;
  logic        valid;
  logic        ready;
  logic [15:0] start_offset;
  logic [27:0] delta_ticks;
  logic [31:0] event_tick;
  logic [7:0]  status_byte;
  logic [7:0]  first_param;
  logic [7:0]  second_param;
  logic [27:0] meta_length;
  logic [1:0]  branch_mark;
  logic [6:0]  branch_index;
  logic [31:0] song_loop_start;
  logic [1:0]  error_code;

  modport source (output valid, output start_offset, output delta_ticks,
                  output event_tick, output status_byte, output first_param,
                  output second_param, output meta_length, output branch_mark,
                  output branch_index, output song_loop_start, output error_code,
                  input ready);
  modport sink   (input valid, input start_offset, input delta_ticks,
                  input event_tick, input status_byte, input first_param,
                  input second_param, input meta_length, input branch_mark,
                  input branch_index, input song_loop_start, input error_code,
                  output ready);
endinterface

// ===== sv/hmp_evp_core.sv =====
// parse state registers and the per-byte next-state and result logic
`timescale 1ns / 1ps
module hmp_evp_core #(
  parameter int BRANCH_SLOTS     = 128,
  parameter int MAX_VARLEN_BYTES = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             new_chunk,
  input  logic             new_song,
  output logic             res_valid,
  output hmp_pkg::result_t res
);
  import hmp_pkg::*;

  localparam int CNT_W  = $clog2(MAX_VARLEN_BYTES + 1);
  localparam int BCNT_W = $clog2(BRANCH_SLOTS + 1);

  phase_t            phase_r, phase_nxt, phase_e;
  logic [VL_W-1:0]   acc_r, acc_nxt, acc_e;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_e;
  logic [15:0]       off_r, off_nxt, off_e;
  logic [15:0]       evs_r, evs_nxt;
  logic [VL_W-1:0]   hdelta_r, hdelta_nxt;
  logic [31:0]       tick_r, tick_nxt, tick_e;
  logic [7:0]        status_r, status_nxt;
  logic [7:0]        first_r, first_nxt;
  logic [VL_W-1:0]   skip_r, skip_nxt;
  logic [BCNT_W-1:0] bcnt_r, bcnt_nxt, bcnt_e;
  logic [31:0]       loop_r, loop_nxt;
  logic              ovl_r, ovl_nxt;

  logic [6:0]        grp;
  logic [3:0]        cnt4;
  logic              can_add;
  logic [VL_W-1:0]   acc_lo;
  logic [VL_W-1:0]   acc_hi;
  logic [BCNT_W-1:0] idx_full;

  assign grp     = data_byte[6:0];
  assign cnt4    = 4'(cnt_e);
  assign can_add = (cnt_e < CNT_W'(MAX_VARLEN_BYTES));
  assign acc_hi  = {acc_e[VL_W-8:0], grp};
  assign idx_full = (bcnt_e < BCNT_W'(BRANCH_SLOTS)) ? bcnt_e : BCNT_W'(BRANCH_SLOTS - 1);

  always_comb begin
    if (cnt4 < 4'd4) begin
      acc_lo = acc_e | (VL_W'(grp) << (5'(cnt4[1:0]) * 5'd7));
    end else begin
      acc_lo = acc_e;
    end
  end

  // chunk start clears tick, offset, branch count and any partial event first
  always_comb begin
    if (new_chunk) begin
      phase_e = PH_DELTA;
      acc_e   = '0;
      cnt_e   = '0;
      off_e   = '0;
      tick_e  = '0;
      bcnt_e  = '0;
    end else begin
      phase_e = phase_r;
      acc_e   = acc_r;
      cnt_e   = cnt_r;
      off_e   = off_r;
      tick_e  = tick_r;
      bcnt_e  = bcnt_r;
    end
  end

  always_comb begin
    phase_nxt  = phase_e;
    acc_nxt    = acc_e;
    cnt_nxt    = cnt_e;
    off_nxt    = off_e + 16'd1;
    evs_nxt    = evs_r;
    hdelta_nxt = hdelta_r;
    tick_nxt   = tick_e;
    status_nxt = status_r;
    first_nxt  = first_r;
    skip_nxt   = skip_r;
    bcnt_nxt   = bcnt_e;
    loop_nxt   = new_song ? 32'd0 : loop_r;
    ovl_nxt    = ovl_r;

    res_valid        = 1'b0;
    res.start_offset = evs_r;
    res.delta_ticks  = hdelta_r;
    res.event_tick   = tick_e;
    res.status_byte  = status_r;
    res.first_param  = 8'd0;
    res.second_param = 8'd0;
    res.meta_length  = '0;
    res.branch_mark  = MARK_NONE;
    res.branch_index = 7'd0;
    res.error_code   = ERR_OK;

    unique case (phase_e)
      PH_DELTA: begin
        if ((cnt_e == '0) && (acc_e == '0)) begin
          evs_nxt = off_e;
          ovl_nxt = 1'b0;
        end
        if (can_add) begin
          acc_nxt = acc_lo;
          cnt_nxt = cnt_e + CNT_W'(1);
        end else begin
          ovl_nxt = 1'b1;
        end
        if (data_byte[7]) begin
          hdelta_nxt = acc_nxt;
          tick_nxt   = tick_e + 32'(acc_nxt);
          phase_nxt  = PH_STATUS;
        end
      end
      PH_STATUS: begin
        status_nxt = data_byte;
        if (data_byte == STATUS_META) begin
          phase_nxt = PH_MTYPE;
        end else if (data_byte[7] && (data_byte[7:4] != NIB_SYS)) begin
          phase_nxt = PH_PARAM1;
        end else begin
          res_valid       = 1'b1;
          res.status_byte = data_byte;
          res.error_code  = ERR_UNKNOWN;
          phase_nxt       = PH_DELTA;
          acc_nxt         = '0;
          cnt_nxt         = '0;
        end
      end
      PH_PARAM1: begin
        first_nxt = data_byte;
        if ((status_r[7:4] == 4'h8) || (status_r[7:4] == 4'h9) ||
            (status_r[7:4] == 4'hA) || (status_r[7:4] == NIB_CTRL) ||
            (status_r[7:4] == 4'hE)) begin
          phase_nxt = PH_PARAM2;
        end else begin
          res_valid       = 1'b1;
          res.first_param = data_byte;
          res.error_code  = ovl_nxt ? ERR_OVERLONG : ERR_OK;
          phase_nxt       = PH_DELTA;
          acc_nxt         = '0;
          cnt_nxt         = '0;
        end
      end
      PH_PARAM2: begin
        if ((status_r[7:4] == NIB_CTRL) &&
            ((first_r == CTRL_LOOP) || (first_r == CTRL_BRANCH))) begin
          res.branch_mark  = (first_r == CTRL_LOOP) ? MARK_LOOP : MARK_BRANCH;
          res.branch_index = 7'(32'(idx_full));
          if ((first_r == CTRL_LOOP) && (loop_nxt == 32'd0)) begin
            loop_nxt = tick_e;
          end
          if (bcnt_e < BCNT_W'(BRANCH_SLOTS)) begin
            bcnt_nxt = bcnt_e + BCNT_W'(1);
          end
        end
        res_valid        = 1'b1;
        res.first_param  = first_r;
        res.second_param = data_byte;
        res.error_code   = ovl_nxt ? ERR_OVERLONG : ERR_OK;
        phase_nxt        = PH_DELTA;
        acc_nxt          = '0;
        cnt_nxt          = '0;
      end
      PH_MTYPE: begin
        first_nxt = data_byte;
        acc_nxt   = '0;
        cnt_nxt   = '0;
        phase_nxt = PH_MLEN;
      end
      PH_MLEN: begin
        if (can_add) begin
          acc_nxt = acc_hi;
          cnt_nxt = cnt_e + CNT_W'(1);
        end else begin
          ovl_nxt = 1'b1;
        end
        if (!data_byte[7]) begin
          if (acc_nxt == '0) begin
            res_valid       = 1'b1;
            res.first_param = first_r;
            res.error_code  = ovl_nxt ? ERR_OVERLONG : ERR_OK;
            phase_nxt       = PH_DELTA;
            acc_nxt         = '0;
            cnt_nxt         = '0;
          end else begin
            skip_nxt  = acc_nxt;
            phase_nxt = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_r - VL_W'(1);
        if (skip_nxt == '0) begin
          res_valid       = 1'b1;
          res.first_param = first_r;
          res.meta_length = acc_e;
          res.error_code  = ovl_nxt ? ERR_OVERLONG : ERR_OK;
          phase_nxt       = PH_DELTA;
          acc_nxt         = '0;
          cnt_nxt         = '0;
        end
      end
      default: begin
        phase_nxt = PH_DELTA;
        acc_nxt   = '0;
        cnt_nxt   = '0;
      end
    endcase

    res.song_loop_start = loop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_DELTA;
      acc_r    <= '0;
      cnt_r    <= '0;
      off_r    <= '0;
      evs_r    <= '0;
      hdelta_r <= '0;
      tick_r   <= '0;
      status_r <= '0;
      first_r  <= '0;
      skip_r   <= '0;
      bcnt_r   <= '0;
      loop_r   <= '0;
      ovl_r    <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
      off_r    <= off_nxt;
      evs_r    <= evs_nxt;
      hdelta_r <= hdelta_nxt;
      tick_r   <= tick_nxt;
      status_r <= status_nxt;
      first_r  <= first_nxt;
      skip_r   <= skip_nxt;
      bcnt_r   <= bcnt_nxt;
      loop_r   <= loop_nxt;
      ovl_r    <= ovl_nxt;
    end
  end

endmodule

// ===== sv/hmp_event_stream_parser_core.sv =====
// top level of the track event parser: byte channel in, event channel out
`timescale 1ns / 1ps
// Takes one byte of track event data per cycle while in_ch.ready is high and
// gives one event item, with its running tick and loop/branch marks, on the byte
// that completes the event. The parse-phase logic handles every byte
// combinationally; the event item goes to the result register, or to the skid
// entry while the output stalls. The output has a result register and one skid
// entry, so input keeps flowing while an event waits; in_ch.ready drops only
// while both hold an event; otherwise the sustained rate is one byte per cycle.
module hmp_event_stream_parser_core #(
  parameter int BRANCH_SLOTS     = 128,
  parameter int MAX_VARLEN_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  hmp_byte_if.sink    in_ch,
  hmp_event_if.source out_ch
);
  import hmp_pkg::*;

  logic    accept;
  logic    push;
  logic    res_valid;
  result_t res;
  result_t out_r, out_nxt;
  result_t skid_r;
  logic    out_valid_r;
  logic    skid_valid_r;

  assign in_ch.ready = !skid_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && res_valid;

  hmp_evp_core #(
    .BRANCH_SLOTS     (BRANCH_SLOTS),
    .MAX_VARLEN_BYTES (MAX_VARLEN_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_ch.data_byte),
    .new_chunk (in_ch.new_chunk),
    .new_song  (in_ch.new_song),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_nxt = skid_valid_r ? skid_r : res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      out_r <= out_nxt;
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.start_offset    = out_r.start_offset;
  assign out_ch.delta_ticks     = out_r.delta_ticks;
  assign out_ch.event_tick      = out_r.event_tick;
  assign out_ch.status_byte     = out_r.status_byte;
  assign out_ch.first_param     = out_r.first_param;
  assign out_ch.second_param    = out_r.second_param;
  assign out_ch.meta_length     = out_r.meta_length;
  assign out_ch.branch_mark     = out_r.branch_mark;
  assign out_ch.branch_index    = out_r.branch_index;
  assign out_ch.song_loop_start = out_r.song_loop_start;
  assign out_ch.error_code      = out_r.error_code;

endmodule

// ===== tb/sv/tb_hmp_event_stream_parser_core.sv =====
// testbench for the track event parser core: byte stream in, predicted event items checked out
`timescale 1ns / 1ps
module tb_hmp_event_stream_parser_core;
  import hmp_pkg::*;

  localparam int BRANCH_SLOTS     = 128;
  localparam int MAX_VARLEN_BYTES = 4;
  localparam int IDLE_LIMIT       = 5000;
  localparam int DRAIN_CYCLES     = 10;
  localparam int HOLD_CYCLES      = 300;
  localparam int RANDOM_BYTES     = 800;

  logic clk;
  logic rst_n;

  hmp_byte_if  in_ch ();
  hmp_event_if out_ch ();

  hmp_event_stream_parser_core #(
    .BRANCH_SLOTS     (BRANCH_SLOTS),
    .MAX_VARLEN_BYTES (MAX_VARLEN_BYTES)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  phase_t      phase       = PH_DELTA;
  logic [27:0] vl_acc      = '0;
  int          vl_cnt      = 0;
  logic [15:0] chunk_pos   = '0;
  logic [15:0] ev_start    = '0;
  logic [27:0] ev_delta    = '0;
  logic [31:0] tick_sum    = '0;
  logic [7:0]  ev_status   = '0;
  logic [7:0]  ev_first    = '0;
  logic [27:0] skip_left   = '0;
  int          branch_cnt  = 0;
  logic [31:0] song_loop   = '0;
  logic        vl_overflow = 1'b0;

  result_t pending_events[$];
  int      mismatches   = 0;
  int      bytes_sent   = 0;
  int      burst_left   = 0;
  bit      gaps_on      = 1'b1;
  bit      restart_next = 1'b0;
  int      rx_hold      = 0;
  int      idle_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic accumulate_group(input logic [7:0] b, input bit high_first);
    if (vl_cnt < MAX_VARLEN_BYTES) begin
      if (high_first) begin
        vl_acc = {vl_acc[20:0], b[6:0]};
      end else if (7 * vl_cnt < 28) begin
        vl_acc = vl_acc | (28'(b[6:0]) << (7 * vl_cnt));
      end
      vl_cnt++;
    end else begin
      vl_overflow = 1'b1;
    end
  endtask

  task automatic push_event(input logic [7:0] first, input logic [7:0] second,
                            input logic [27:0] mlen, input mark_t mark,
                            input logic [6:0] idx, input err_t err);
    result_t ev;
    ev.start_offset    = ev_start;
    ev.delta_ticks     = ev_delta;
    ev.event_tick      = tick_sum;
    ev.status_byte     = ev_status;
    ev.first_param     = first;
    ev.second_param    = second;
    ev.meta_length     = mlen;
    ev.branch_mark     = mark;
    ev.branch_index    = idx;
    ev.song_loop_start = song_loop;
    ev.error_code      = err;
    pending_events.insert(pending_events.size(), ev);
    phase  = PH_DELTA;
    vl_acc = '0;
    vl_cnt = 0;
  endtask

  task automatic predict_track_byte(input logic [7:0] b, input logic nc, input logic ns);
    mark_t       mark;
    logic [6:0]  idx;
    err_t        len_err;
    len_err = vl_overflow ? ERR_OVERLONG : ERR_OK;
    if (ns) song_loop = '0;
    if (nc) begin
      tick_sum   = '0;
      chunk_pos  = '0;
      branch_cnt = 0;
      phase      = PH_DELTA;
      vl_acc     = '0;
      vl_cnt     = 0;
    end
    case (phase)
      PH_DELTA: begin
        if (vl_cnt == 0 && vl_acc == '0) begin
          ev_start    = chunk_pos;
          vl_overflow = 1'b0;
        end
        accumulate_group(b, 1'b0);
        if (b[7]) begin
          ev_delta = vl_acc;
          tick_sum = tick_sum + 32'(ev_delta);
          phase    = PH_STATUS;
        end
      end
      PH_STATUS: begin
        ev_status = b;
        if (b == STATUS_META) begin
          phase = PH_MTYPE;
        end else if (b[7:4] >= 4'h8 && b[7:4] <= 4'hE) begin
          phase = PH_PARAM1;
        end else begin
          push_event('0, '0, '0, MARK_NONE, '0, ERR_UNKNOWN);
        end
      end
      PH_PARAM1: begin
        ev_first = b;
        if (ev_status[7:4] inside {4'h8, 4'h9, 4'hA, 4'hB, 4'hE}) begin
          phase = PH_PARAM2;
        end else begin
          push_event(b, '0, '0, MARK_NONE, '0, len_err);
        end
      end
      PH_PARAM2: begin
        mark = MARK_NONE;
        idx  = '0;
        if (ev_status[7:4] == NIB_CTRL && (ev_first == CTRL_LOOP || ev_first == CTRL_BRANCH)) begin
          mark = (ev_first == CTRL_LOOP) ? MARK_LOOP : MARK_BRANCH;
          if (mark == MARK_LOOP && song_loop == '0) song_loop = tick_sum;
          idx = 7'((branch_cnt < BRANCH_SLOTS) ? branch_cnt : BRANCH_SLOTS - 1);
          if (branch_cnt < BRANCH_SLOTS) branch_cnt++;
        end
        push_event(ev_first, b, '0, mark, idx, len_err);
      end
      PH_MTYPE: begin
        ev_first = b;
        vl_acc   = '0;
        vl_cnt   = 0;
        phase    = PH_MLEN;
      end
      PH_MLEN: begin
        accumulate_group(b, 1'b1);
        if (!b[7]) begin
          if (vl_acc == '0) begin
            push_event(ev_first, '0, '0, MARK_NONE, '0, vl_overflow ? ERR_OVERLONG : ERR_OK);
          end else begin
            skip_left = vl_acc;
            phase     = PH_SKIP;
          end
        end
      end
      default: begin
        skip_left = skip_left - 28'd1;
        if (skip_left == '0) push_event(ev_first, '0, vl_acc, MARK_NONE, '0, len_err);
      end
    endcase
    chunk_pos = chunk_pos + 16'd1;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic nc, input logic ns);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        @(negedge clk) in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.new_chunk <= nc;
    in_ch.new_song  <= ns;
    do @(posedge clk); while (!in_ch.ready);
    predict_track_byte(b, nc, ns);
    bytes_sent++;
  endtask

  function automatic logic [7:0] rand_param();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 127));
  endfunction

  // low group first, stop bit on the last byte
  task automatic send_delta(input int groups, input logic nc, input logic ns, input bit saturate);
    logic [7:0] b;
    for (int i = 0; i < groups; i++) begin
      b = saturate ? 8'h7F : 8'($urandom_range(0, 127));
      if (i == groups - 1) b[7] = 1'b1;
      send_byte(b, (i == 0) ? nc : 1'b0, (i == 0) ? ns : 1'b0);
    end
  endtask

  task automatic send_meta(input logic [7:0] kind, input int len);
    int n;
    send_byte(STATUS_META, 0, 0);
    send_byte(kind, 0, 0);
    n = 1;
    while (n < 4 && (len >> (7 * n)) != 0) n++;
    for (int i = n - 1; i >= 0; i--) begin
      send_byte({(i > 0), 7'((len >> (7 * i)) & 'h7F)}, 0, 0);
    end
    repeat (len) send_byte(8'($urandom_range(0, 255)), 0, 0);
  endtask

  task automatic send_random_event();
    int         r;
    int         n;
    int         len;
    logic       nc;
    logic       ns;
    logic [7:0] st;
    nc = restart_next || ($urandom_range(0, 149) == 0);
    ns = ($urandom_range(0, 99) == 0);
    restart_next = 1'b0;
    r = $urandom_range(0, 99);
    n = (r < 60) ? 1 : (r < 80) ? 2 : (r < 88) ? 3 : (r < 95) ? 4 : $urandom_range(5, 6);
    send_delta(n, nc, ns, ($urandom_range(0, 9) == 0));
    // broken event: whatever follows is parsed as status
    if ($urandom_range(0, 79) == 0) return;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      if (r < 15) begin
        st = {NIB_CTRL, 4'($urandom_range(0, 15))};
      end else if (r < 27) begin
        st = {($urandom_range(0, 1) ? 4'hD : 4'hC), 4'($urandom_range(0, 15))};
      end else begin
        n  = $urandom_range(0, 3);
        st = {((n == 3) ? 4'hE : 4'(8 + n)), 4'($urandom_range(0, 15))};
      end
      send_byte(st, 0, 0);
      if ($urandom_range(0, 149) == 0) begin
        restart_next = 1'b1;
        return;
      end
      if (st[7:4] == NIB_CTRL) begin
        n = $urandom_range(0, 2);
        send_byte((n == 0) ? CTRL_LOOP : (n == 1) ? CTRL_BRANCH : rand_param(), 0, 0);
      end else begin
        send_byte(rand_param(), 0, 0);
      end
      if (!(st[7:4] inside {4'hC, 4'hD})) send_byte(rand_param(), 0, 0);
    end else if (r < 73) begin
      n = $urandom_range(0, 99);
      if (n < 20) begin
        send_meta(8'($urandom_range(0, 255)), 0);
      end else if (n < 80) begin
        send_meta(8'($urandom_range(0, 255)), $urandom_range(1, 20));
      end else if (n < 92) begin
        send_meta(8'($urandom_range(0, 255)), $urandom_range(128, 511));
      end else begin
        // more than four length groups, the tail is dropped
        len = $urandom_range(0, 10);
        send_byte(STATUS_META, 0, 0);
        send_byte(8'($urandom_range(0, 255)), 0, 0);
        repeat (3) send_byte(8'h80, 0, 0);
        send_byte(8'h80 | 8'(len), 0, 0);
        repeat ($urandom_range(0, 1)) send_byte(8'h80 | 8'($urandom_range(0, 127)), 0, 0);
        send_byte(8'($urandom_range(0, 127)), 0, 0);
        repeat (len) send_byte(8'($urandom_range(0, 255)), 0, 0);
      end
    end else if (r < 88) begin
      if ($urandom_range(0, 1)) st = 8'($urandom_range(0, 8'h7F));
      else st = 8'($urandom_range(8'hF0, 8'hFE));
      send_byte(st, 0, 0);
    end else begin
      send_byte(8'($urandom_range(0, 255)), 0, 0);
    end
  endtask

  task automatic test_directed_commands();
    send_byte(8'h80, 1, 1); send_byte(8'h90, 0, 0); send_byte(8'h3C, 0, 0); send_byte(8'h7F, 0, 0);
    send_byte(8'h00, 0, 0); send_byte(8'h81, 0, 0); send_byte(8'hC5, 0, 0); send_byte(8'h10, 0, 0);
    send_byte(8'h8A, 0, 0); send_byte(8'hE0, 0, 0); send_byte(8'hFF, 0, 0); send_byte(8'hFF, 0, 0);
    send_byte(8'h80, 0, 0); send_byte(8'hFF, 0, 0); send_byte(8'h2F, 0, 0); send_byte(8'h00, 0, 0);
    send_byte(8'h81, 0, 0); send_byte(8'hFF, 0, 0); send_byte(8'h01, 0, 0); send_byte(8'h02, 0, 0);
    send_byte(8'hAA, 0, 0); send_byte(8'h55, 0, 0);
    send_byte(8'h80, 0, 0); send_byte(8'h40, 0, 0);
    send_byte(8'h80, 0, 0); send_byte(8'hF0, 0, 0);
    send_byte(8'h80, 0, 0); send_byte(8'hD3, 0, 0); send_byte(8'h00, 0, 0);
    send_byte(8'h80, 0, 0); send_byte(8'hFE, 0, 0);
  endtask

  task automatic test_loop_and_branch();
    // loop start at tick zero leaves the song loop unset
    send_byte(8'h80, 1, 0); send_byte(8'hB0, 0, 0); send_byte(CTRL_LOOP, 0, 0); send_byte(8'h00, 0, 0);
    send_byte(8'h85, 0, 0); send_byte(8'hB3, 0, 0); send_byte(CTRL_BRANCH, 0, 0); send_byte(8'h40, 0, 0);
    send_byte(8'h83, 0, 0); send_byte(8'hB0, 0, 0); send_byte(CTRL_LOOP, 0, 0); send_byte(8'h7F, 0, 0);
    send_byte(8'h80, 0, 0); send_byte(8'hB0, 0, 0); send_byte(CTRL_LOOP, 0, 0); send_byte(8'h00, 0, 0);
    send_byte(8'h81, 0, 1); send_byte(8'hBF, 0, 0); send_byte(CTRL_LOOP, 0, 0); send_byte(8'h01, 0, 0);
    send_byte(8'h80, 0, 0); send_byte(8'hB0, 0, 0); send_byte(8'd109, 0, 0); send_byte(8'h05, 0, 0);
    send_byte(8'h80, 0, 0); send_byte(8'hA0, 0, 0); send_byte(CTRL_LOOP, 0, 0); send_byte(8'h00, 0, 0);
  endtask

  task automatic test_overlong_lengths();
    repeat (4) send_byte(8'h7F, 0, 0);
    send_byte(8'hFF, 0, 0); send_byte(8'h90, 0, 0); send_byte(8'h01, 0, 0); send_byte(8'h02, 0, 0);
    send_byte(8'h80, 0, 0); send_byte(8'hFF, 0, 0); send_byte(8'h06, 0, 0);
    repeat (3) send_byte(8'h80, 0, 0);
    send_byte(8'h81, 0, 0); send_byte(8'h80, 0, 0); send_byte(8'h00, 0, 0); send_byte(8'hEE, 0, 0);
    send_byte(8'h80, 0, 0); send_byte(8'hFF, 0, 0); send_byte(8'h07, 0, 0);
    repeat (4) send_byte(8'h80, 0, 0);
    send_byte(8'h05, 0, 0);
    // unknown command wins over an overlong delta
    repeat (5) send_byte(8'h00, 0, 0);
    send_byte(8'h80, 0, 0); send_byte(8'h20, 0, 0);
  endtask

  task automatic test_chunk_restart();
    send_byte(8'h85, 0, 0); send_byte(8'h90, 0, 0); send_byte(8'h11, 0, 0);
    send_byte(8'h82, 1, 0); send_byte(8'hB0, 0, 0); send_byte(CTRL_BRANCH, 0, 0); send_byte(8'h01, 0, 0);
    send_byte(8'h80, 0, 0); send_byte(8'hFF, 0, 0); send_byte(8'h01, 0, 0); send_byte(8'h05, 0, 0);
    send_byte(8'h11, 0, 0); send_byte(8'h22, 0, 0);
    send_byte(8'h83, 1, 0); send_byte(8'hC0, 0, 0); send_byte(8'h01, 0, 0);
  endtask

  task automatic test_tick_wrap();
    for (int i = 0; i < 20; i++) begin
      send_delta(4, (i == 0), 1'b0, 1'b1);
      send_byte({4'hA, 4'($urandom_range(0, 15))}, 0, 0);
      send_byte(rand_param(), 0, 0);
      send_byte(rand_param(), 0, 0);
    end
  endtask

  task automatic test_branch_table_full();
    for (int i = 0; i < BRANCH_SLOTS + 12; i++) begin
      send_delta(1, (i == 0), 1'b0, 1'b0);
      send_byte({NIB_CTRL, 4'($urandom_range(0, 15))}, 0, 0);
      send_byte($urandom_range(0, 1) ? CTRL_LOOP : CTRL_BRANCH, 0, 0);
      send_byte(rand_param(), 0, 0);
    end
  endtask

  task automatic test_long_meta();
    send_delta(1, 1'b1, 1'b0, 1'b0);
    send_meta(8'h7F, 300);
    repeat (5) send_random_event();
  endtask

  task automatic test_output_backpressure();
    gaps_on = 1'b0;
    rx_hold = HOLD_CYCLES;
    repeat (40) begin
      send_delta(1, 1'b0, 1'b0, 1'b0);
      send_byte({4'hC, 4'($urandom_range(0, 15))}, 0, 0);
      send_byte(rand_param(), 0, 0);
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_random_stream();
    int base;
    base = bytes_sent;
    while (bytes_sent - base < RANDOM_BYTES) send_random_event();
  endtask

  // receiver stall pattern
  initial begin
    int         seg;
    int         mode;
    logic [15:0] pat;
    logic       r;
    out_ch.ready = 1'b0;
    seg  = 0;
    mode = 0;
    pat  = '1;
    forever begin
      @(negedge clk);
      if (seg == 0) begin
        seg  = $urandom_range(20, 300);
        mode = $urandom_range(0, 3);
        pat  = 16'($urandom) | 16'h1;
      end
      seg--;
      case (mode)
        0: r = 1'b1;
        1: r = 1'($urandom_range(0, 1));
        2: begin
          r   = pat[0];
          pat = {pat[0], pat[15:1]};
        end
        default: r = ($urandom_range(0, 5) == 0);
      endcase
      if (rx_hold > 0) begin
        r = 1'b0;
        rx_hold--;
      end
      out_ch.ready <= r;
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t ev;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected event item at offset 0x%0h", out_ch.start_offset);
        mismatches++;
      end else begin
        ev = pending_events.pop_front();
        check_field("start_offset", 32'(ev.start_offset), 32'(out_ch.start_offset));
        check_field("delta_ticks", 32'(ev.delta_ticks), 32'(out_ch.delta_ticks));
        check_field("event_tick", ev.event_tick, out_ch.event_tick);
        check_field("status_byte", 32'(ev.status_byte), 32'(out_ch.status_byte));
        check_field("first_param", 32'(ev.first_param), 32'(out_ch.first_param));
        check_field("second_param", 32'(ev.second_param), 32'(out_ch.second_param));
        check_field("meta_length", 32'(ev.meta_length), 32'(out_ch.meta_length));
        check_field("branch_mark", 32'(ev.branch_mark), 32'(out_ch.branch_mark));
        check_field("branch_index", 32'(ev.branch_index), 32'(out_ch.branch_index));
        check_field("song_loop_start", ev.song_loop_start, out_ch.song_loop_start);
        check_field("error_code", 32'(ev.error_code), 32'(out_ch.error_code));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("hmp_event_stream_parser_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.new_chunk = 1'b0;
    in_ch.new_song  = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_directed_commands();
    test_loop_and_branch();
    test_overlong_lengths();
    test_chunk_restart();
    test_tick_wrap();
    test_branch_table_full();
    test_output_backpressure();
    test_long_meta();
    test_random_stream();

    @(negedge clk) in_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("hmp_event_stream_parser_core verification clean");
    end else begin
      $display("hmp_event_stream_parser_core verification failed");
    end
    $finish;
  end

endmodule
